/* sv/cfs_pkg.sv */
`default_nettype none

package cfs_pkg;

    localparam int unsigned CFG_WIDTH = 32;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] FIX_ONE     = 64'd1 << 30;

    localparam int unsigned HORNER_TERMS = 6;
    localparam logic [7:0] SIN_DIV [HORNER_TERMS] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } t_quad;

endpackage

`default_nettype wire

/* sv/complex_frequency_shifter.sv */
`default_nettype none

// An accepted request waits in the input register, then its result moves to the
// result register. The phase quadrant and both sine ROM reads are registered with the
// request; multiply, round and saturate run between the input and result registers.
// Throughput: one request per cycle; ready drops only while both registers are full
// and the result is stalled. Reset (i_rst_n low, synchronous) zeroes the phase
// accumulator and phase step and empties both registers; the sine ROM is constant.
module complex_frequency_shifter
    import cfs_pkg::*;
#(
    parameter int SAMPLE_WIDTH    = 16,
    parameter int PHASE_WIDTH     = 32,
    parameter int TABLE_ADDR_BITS = 10
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_wr_en,
    input  wire        [CFG_WIDTH-1:0]    i_cfg_wr_data,
    input  wire                           i_in_valid,
    output logic                          o_in_ready,
    input  wire signed [SAMPLE_WIDTH-1:0] i_sample_i,
    input  wire signed [SAMPLE_WIDTH-1:0] i_sample_q,
    input  wire                           i_last_sample,
    output logic                          o_out_valid,
    input  wire                           i_out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] o_shifted_i,
    output logic signed [SAMPLE_WIDTH-1:0] o_shifted_q,
    output logic                          o_last_out
);

    localparam int TAB_N    = 1 << TABLE_ADDR_BITS;
    localparam int ROM_AW   = TABLE_ADDR_BITS + 1;
    localparam int PROD_W   = 2 * SAMPLE_WIDTH;
    localparam int SUM_W    = PROD_W + 2;
    localparam int IDX_LSB  = PHASE_WIDTH - TABLE_ADDR_BITS - 2;

    localparam logic signed [SUM_W-1:0] ROUND_ADD = SUM_W'(64'd1 << (SAMPLE_WIDTH - 2));
    localparam logic signed [SUM_W-1:0] SAT_MAX =
        SUM_W'((64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - SUM_W'(1);

    typedef logic signed [SAMPLE_WIDTH-1:0] t_rom [TAB_N+1];

    function automatic logic signed [SAMPLE_WIDTH-1:0] rom_entry(input int unsigned k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] r;
        logic [63:0] cap;
        int          sh;
        x   = (HALF_PI_Q30 * 64'(k)) >> TABLE_ADDR_BITS;
        x2  = (x * x) >> 30;
        t   = FIX_ONE;
        cap = (64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1;
        for (int i = 0; i < HORNER_TERMS; i++) begin
            t = FIX_ONE - ((x2 * t) >> 30) / 64'(SIN_DIV[i]);
        end
        s = (x * t) >> 30;
        if (SAMPLE_WIDTH - 1 <= 30) begin
            sh = 31 - SAMPLE_WIDTH;
            if (sh == 0) begin
                r = s;
            end else begin
                r = (s + (64'd1 << (sh - 1))) >> sh;
            end
        end else begin
            r = s << (SAMPLE_WIDTH - 31);
        end
        if (r > cap) begin
            r = cap;
        end
        return r[SAMPLE_WIDTH-1:0];
    endfunction

    function automatic t_rom build_rom();
        t_rom rom;
        for (int k = 0; k <= TAB_N; k++) begin
            rom[k] = rom_entry(k);
        end
        return rom;
    endfunction

    localparam t_rom SIN_ROM = build_rom();

    function automatic logic signed [SAMPLE_WIDTH-1:0] round_sat(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [SUM_W-1:0] sh;
        sh = (v + ROUND_ADD) >>> (SAMPLE_WIDTH - 1);
        if (sh > SAT_MAX) begin
            sh = SAT_MAX;
        end else if (sh < SAT_MIN) begin
            sh = SAT_MIN;
        end
        return sh[SAMPLE_WIDTH-1:0];
    endfunction

    logic signed [CFG_WIDTH-1:0]    r_step;
    logic        [PHASE_WIDTH-1:0]  r_acc;

    logic                           r_in_v;
    logic signed [SAMPLE_WIDTH-1:0] r_in_i;
    logic signed [SAMPLE_WIDTH-1:0] r_in_q;
    logic                           r_in_last;
    t_quad                          r_in_quad;
    logic signed [SAMPLE_WIDTH-1:0] r_in_lo;
    logic signed [SAMPLE_WIDTH-1:0] r_in_hi;

    logic                           r_out_v;
    logic signed [SAMPLE_WIDTH-1:0] r_out_i;
    logic signed [SAMPLE_WIDTH-1:0] r_out_q;
    logic                           r_out_last;

    logic                           adv_in;
    logic                           adv_out;
    logic                           accept;
    logic        [PHASE_WIDTH-1:0]  step_ext;
    logic        [PHASE_WIDTH-1:0]  n_acc;
    logic        [ROM_AW-1:0]       lo_addr;
    logic        [ROM_AW-1:0]       hi_addr;
    logic signed [SAMPLE_WIDTH-1:0] sn;
    logic signed [SAMPLE_WIDTH-1:0] cs;
    logic signed [PROD_W-1:0]       prod_ic;
    logic signed [PROD_W-1:0]       prod_qs;
    logic signed [PROD_W-1:0]       prod_is;
    logic signed [PROD_W-1:0]       prod_qc;
    logic signed [SUM_W-1:0]        n_sum_i;
    logic signed [SUM_W-1:0]        n_sum_q;

    assign adv_out    = !r_out_v || i_out_ready;
    assign adv_in     = !r_in_v || adv_out;
    assign o_in_ready = adv_in;
    assign accept     = i_in_valid && adv_in;

    assign step_ext = PHASE_WIDTH'(r_step);
    assign n_acc    = i_last_sample ? '0 : r_acc + step_ext;

    assign lo_addr = {1'b0, r_acc[IDX_LSB +: TABLE_ADDR_BITS]};
    assign hi_addr = ROM_AW'(TAB_N) - lo_addr;

    always_comb begin
        case (r_in_quad)
            QUAD_0: begin
                sn = r_in_lo;
                cs = r_in_hi;
            end
            QUAD_1: begin
                sn = r_in_hi;
                cs = -r_in_lo;
            end
            QUAD_2: begin
                sn = -r_in_lo;
                cs = -r_in_hi;
            end
            default: begin
                sn = -r_in_hi;
                cs = r_in_lo;
            end
        endcase
    end

    assign prod_ic = r_in_i * cs;
    assign prod_qs = r_in_q * sn;
    assign prod_is = r_in_i * sn;
    assign prod_qc = r_in_q * cs;

    assign n_sum_i = SUM_W'(prod_ic) - SUM_W'(prod_qs);
    assign n_sum_q = SUM_W'(prod_is) + SUM_W'(prod_qc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_acc   <= '0;
            r_in_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_step <= i_cfg_wr_data;
            end
            if (accept) begin
                r_acc <= n_acc;
            end
            if (adv_in) begin
                r_in_v <= i_in_valid;
            end
            if (adv_out) begin
                r_out_v <= r_in_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_i    <= i_sample_i;
            r_in_q    <= i_sample_q;
            r_in_last <= i_last_sample;
            r_in_quad <= t_quad'(r_acc[PHASE_WIDTH-1 -: 2]);
            r_in_lo   <= SIN_ROM[lo_addr];
            r_in_hi   <= SIN_ROM[hi_addr];
        end
        if (adv_out) begin
            r_out_last <= r_in_last;
            r_out_i    <= round_sat(n_sum_i);
            r_out_q    <= round_sat(n_sum_q);
        end
    end

    assign o_out_valid = r_out_v;
    assign o_shifted_i = r_out_i;
    assign o_shifted_q = r_out_q;
    assign o_last_out  = r_out_last;

endmodule

`default_nettype wire

/* sv/cfs_checker.sv */
`default_nettype none

module cfs_assertions #(
    parameter int SAMPLE_WIDTH = 16
) (
    input wire                    i_clk,
    input wire                    i_rst_n,
    input wire                    i_in_valid,
    input wire                    o_in_ready,
    input wire                    o_out_valid,
    input wire                    i_out_ready,
    input wire [SAMPLE_WIDTH-1:0] o_shifted_i,
    input wire [SAMPLE_WIDTH-1:0] o_shifted_q,
    input wire                    o_last_out
);

    logic [2:0] r_cnt;
    logic [2:0] n_cnt;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;
    assign n_cnt   = r_cnt + 3'(in_acc) - 3'(out_acc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_shifted_i) && $stable(o_shifted_q)
            && $stable(o_last_out))
        else $error("stalled result changed");

    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 3'd0 |-> !o_out_valid)
        else $error("result with no request in flight");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd2)
        else $error("more requests in flight than registers");

    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready && r_cnt == 3'd2)
        else $error("input stalled while pipeline has room");

endmodule

bind complex_frequency_shifter cfs_assertions #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_cfs_assertions (.*);

`default_nettype wire
